[hw/rtl/bkte_pkg.sv]
`default_nettype none
package bkte_pkg;

	localparam int BUCKET_BITS = 8;
	localparam int BUCKETS     = 1 << BUCKET_BITS;
	localparam int WAY_BITS    = 4;
	localparam int WAYS        = 1 << WAY_BITS;
	localparam int ROW_BITS    = BUCKET_BITS + WAY_BITS;
	localparam int ROWS        = 1 << ROW_BITS;
	localparam int ENTRY_WORDS = 32;
	localparam int ENTRY_BITS  = ENTRY_WORDS * 32;
	localparam int SCR_BITS    = ENTRY_BITS - 32;
	localparam int REC_WORDS   = 5;
	localparam int PASSES      = 10;
	localparam int PASS_BITS   = 4;

	localparam logic [7:0] PROTO_TCP = 8'h06;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_PACKET = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [31:0] record_word0;
		logic [31:0] record_word1;
		logic [31:0] record_word2;
		logic [31:0] record_word3;
		logic [31:0] record_word4;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_protocol;
		logic        record_placed;
		logic [3:0]  packet_new;
		logic [3:0]  packet_hits;
		logic [3:0]  packet_misses;
		logic [31:0] new_total;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] load_set_total;
		logic [31:0] load_lost_total;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD_WR,
		OP_LOST,
		OP_INSERT,
		OP_HIT,
		OP_MISS,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic                latch;
		logic                clearing;
		logic [ROW_BITS-1:0] clr_row;
		logic [WAY_BITS-1:0] way;
		op_t                 op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       tcp;
		logic       key_empty;
		logic       key_match;
		logic       out_free;
	} status_t;

endpackage
`default_nettype wire

[hw/rtl/bucketed_key_table_engine_core.sv]
`default_nettype none
// Bucketed key table: 256 buckets x 16 ways of 32-word entries, one result item
// per input item. After reset the block sweeps its 4096-row entry memory to zero,
// one row a cycle, with in_stall high. Every way probe is a read state (address),
// then a check state (registered read and compare) on the single memory port.
// A load item probes ways until it finds an empty one (up to 16); a TCP packet
// runs ten passes, each probing ways up to an empty, matching or last way; other
// items go straight to emit. A stalled result delays taking the next item.
// cfg_ready is always high; write bucket_mask only while no item is in flight.
module bucketed_key_table_engine_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  bkte_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  wire                  out_stall,
	output bkte_pkg::out_item_t  out_item,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [7:0]           cfg_data
);
	import bkte_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	bkte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bkte_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

[hw/rtl/bkte_ctrl.sv]
`default_nettype none
module bkte_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  bkte_pkg::status_t  status,
	output bkte_pkg::cmd_t     cmd
);
	import bkte_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_CHECK,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [ROW_BITS-1:0]  clr_q;
	logic [WAY_BITS-1:0]  way_q;
	logic [PASS_BITS-1:0] pass_q;

	logic last_way;
	logic last_pass;
	logic pass_end;

	assign last_way  = (way_q == WAY_BITS'(WAYS - 1));
	assign last_pass = (pass_q == PASS_BITS'(PASSES - 1));
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.latch    = (state_q == S_IDLE) && in_valid;
		cmd.clearing = (state_q == S_CLEAR);
		cmd.clr_row  = clr_q;
		cmd.way      = way_q;
		pass_end     = 1'b0;
		case (state_q)
			S_CHECK: begin
				if (status.mode == MODE_LOAD) begin
					if (status.key_empty) cmd.op = OP_LOAD_WR;
					else if (last_way) cmd.op = OP_LOST;
				end else begin
					if (status.key_empty) begin
						cmd.op   = OP_INSERT;
						pass_end = 1'b1;
					end else if (status.key_match) begin
						cmd.op   = OP_HIT;
						pass_end = 1'b1;
					end else if (last_way) begin
						cmd.op   = OP_MISS;
						pass_end = 1'b1;
					end
				end
			end
			S_EMIT: begin
				if (status.out_free) cmd.op = OP_EMIT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			way_q   <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					way_q  <= '0;
					pass_q <= '0;
					if (status.mode == MODE_LOAD ||
					    (status.mode == MODE_PACKET && status.tcp))
						state_q <= S_READ;
					else
						state_q <= S_EMIT;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (status.mode == MODE_LOAD) begin
						if (status.key_empty || last_way) begin
							state_q <= S_EMIT;
						end else begin
							way_q   <= way_q + 1'b1;
							state_q <= S_READ;
						end
					end else if (pass_end) begin
						way_q <= '0;
						if (last_pass) begin
							state_q <= S_EMIT;
						end else begin
							pass_q  <= pass_q + 1'b1;
							state_q <= S_READ;
						end
					end else begin
						way_q   <= way_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_EMIT: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bkte_dp.sv]
`default_nettype none
module bkte_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bkte_pkg::in_item_t   in_item,
	input  wire                  cfg_valid,
	input  wire  [7:0]           cfg_data,
	input  bkte_pkg::cmd_t       cmd,
	output bkte_pkg::status_t    status,
	output logic                 out_valid,
	input  wire                  out_stall,
	output bkte_pkg::out_item_t  out_item
);
	import bkte_pkg::*;

	logic [ENTRY_BITS-1:0] mem_q [ROWS];
	logic [ENTRY_BITS-1:0] rd_q;
	logic [SCR_BITS-1:0]   scratch_q;
	in_item_t              item_q;
	logic [7:0]            mask_q;
	logic [31:0]           new_q, hit_q, miss_q, set_q, lost_q;
	logic [3:0]            nn_q, nh_q, nm_q;
	logic                  placed_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic [31:0]             hash;
	logic [ROW_BITS-1:0]     addr;
	logic [ENTRY_BITS-1:0]   wdata;
	logic [ENTRY_WORDS-1:0]  we;
	logic [7:0]              oproto;

	assign hash = (item_q.mode == MODE_LOAD) ? item_q.record_word4 : item_q.dest_address;
	assign addr = cmd.clearing ? cmd.clr_row : {hash[BUCKET_BITS-1:0] & mask_q, cmd.way};

	always_comb begin
		wdata = '0;
		we    = '0;
		if (cmd.clearing) begin
			we = '1;
		end else begin
			case (cmd.op)
				OP_LOAD_WR: begin
					we[REC_WORDS-1:0] = '1;
					wdata[159:0] = {item_q.record_word4, item_q.record_word3,
						item_q.record_word2, item_q.record_word1, item_q.record_word0};
				end
				OP_INSERT: begin
					we[0]        = 1'b1;
					wdata[31:0]  = item_q.source_address;
				end
				OP_HIT: begin
					// odd running hit count pushes scratch into the entry
					if (hit_q[0]) begin
						we[ENTRY_WORDS-1:1]     = '1;
						wdata[ENTRY_BITS-1:32]  = scratch_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < ENTRY_WORDS; w++) begin
			if (we[w]) mem_q[addr][w*32 +: 32] <= wdata[w*32 +: 32];
		end
		rd_q <= mem_q[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_item;
	end

	assign oproto = (item_q.mode != MODE_PACKET) ? 8'd0 :
		(item_q.protocol == PROTO_TCP) ? PROTO_UDP : item_q.protocol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= 8'hFF;
			scratch_q   <= '0;
			new_q       <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			set_q       <= '0;
			lost_q      <= '0;
			nn_q        <= '0;
			nh_q        <= '0;
			nm_q        <= '0;
			placed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) mask_q <= cfg_data;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cmd.latch) begin
				nn_q     <= '0;
				nh_q     <= '0;
				nm_q     <= '0;
				placed_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD_WR: begin
					set_q    <= set_q + 1'b1;
					placed_q <= 1'b1;
				end
				OP_LOST: lost_q <= lost_q + 1'b1;
				OP_INSERT: begin
					new_q <= new_q + 1'b1;
					nn_q  <= nn_q + 1'b1;
				end
				OP_HIT: begin
					if (!hit_q[0]) scratch_q <= rd_q[ENTRY_BITS-1:32];
					hit_q <= hit_q + 1'b1;
					nh_q  <= nh_q + 1'b1;
				end
				OP_MISS: begin
					miss_q <= miss_q + 1'b1;
					nm_q   <= nm_q + 1'b1;
				end
				OP_EMIT: begin
					if (item_q.mode == MODE_TICK) begin
						hit_q  <= '0;
						miss_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_q.out_protocol    <= oproto;
			out_q.record_placed   <= placed_q;
			out_q.packet_new      <= nn_q;
			out_q.packet_hits     <= nh_q;
			out_q.packet_misses   <= nm_q;
			out_q.new_total       <= new_q;
			out_q.hit_total       <= (item_q.mode == MODE_TICK) ? 32'd0 : hit_q;
			out_q.miss_total      <= (item_q.mode == MODE_TICK) ? 32'd0 : miss_q;
			out_q.load_set_total  <= set_q;
			out_q.load_lost_total <= lost_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign status.mode      = item_q.mode;
	assign status.tcp       = (item_q.protocol == PROTO_TCP);
	assign status.key_empty = (rd_q[31:0] == 32'd0);
	assign status.key_match = (rd_q[31:0] == item_q.source_address);
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

[hw/rtl/bkte_checker.sv]
`default_nettype none
module bkte_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_stall,
	input bkte_pkg::out_item_t  out_item
);
	import bkte_pkg::*;

	logic [4:0] count_sum;
	assign count_sum = {1'b0, out_item.packet_new} + {1'b0, out_item.packet_hits}
		+ {1'b0, out_item.packet_misses};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("stalled result item changed");

	a_passes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_sum == 5'd0 || count_sum == 5'(PASSES)))
		else $error("packet pass counts do not add up");

	a_placed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.record_placed |->
			out_item.out_protocol == 8'd0 && count_sum == 5'd0)
		else $error("load result carries packet fields");

endmodule

bind bucketed_key_table_engine_core bkte_checker u_bkte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire
